@@ rtl/cpa_pkg.sv @@
// Shared constants, types and helpers for the colored page allocator.
// Used by colored_page_allocator and cpa_prio under rtl; depends on nothing.
`timescale 1ns / 1ps

package cpa_pkg;

	localparam int NUM_PAGES  = 4096;
	localparam int NUM_COLORS = 16;

	localparam int PAGE_W  = 12;            // page_index / granted_page width
	localparam int CNT_W   = 13;            // pages_free width
	localparam int MASK_W  = 16;            // color_mask width
	localparam int MASK_IW = $clog2(MASK_W);

	// Free map is stored as words of WORD_W pages; page color repeats every word.
	localparam int WORD_W    = 64;
	localparam int BIT_W     = $clog2(WORD_W);
	localparam int NUM_WORDS = NUM_PAGES / WORD_W;
	localparam int WORD_AW   = $clog2(NUM_WORDS);

	// Priority encoder split into groups.
	localparam int GRP_W   = 8;
	localparam int NUM_GRP = WORD_W / GRP_W;
	localparam int GRP_IW  = $clog2(NUM_GRP);
	localparam int GBIT_W  = $clog2(GRP_W);

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NONE    = 2'd1;
	localparam logic [1:0] ST_IGNORED = 2'd2;

	localparam logic [CNT_W-1:0] PAGES_MAX = CNT_W'(NUM_PAGES);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_GRANT,
		S_FRD,
		S_FWR,
		S_DONE
	} state_t;

	typedef struct packed {
		logic             found;
		logic [BIT_W-1:0] idx;
	} hit_t;

	// Expand a color mask into the allowed-bit pattern of one map word.
	function automatic logic [WORD_W-1:0] expand_mask(input logic [MASK_W-1:0] mask);
		logic [WORD_W-1:0]  allowed;
		logic [MASK_IW-1:0] ci;
		allowed = '0;
		for (int b = 0; b < WORD_W; b++) begin
			ci = MASK_IW'(b % NUM_COLORS);
			if ((b % NUM_COLORS) < MASK_W) begin
				allowed[b] = mask[ci];
			end
		end
		return allowed;
	endfunction

endpackage

@@ rtl/colored_page_allocator.sv @@
// Colored page allocator: free bitmap in a word-wide RAM, scanned from the top word down.
// Allocate: map words are read one per cycle through the RAM read port until a hit or word
// zero is checked; a hit word is written back. A free reads its word, then updates it.
// Throughput: one item at a time; the next is taken in the cycle after the result loads,
// and the result does not load while the output stalls.
// Reset: the map reads all zero through per-word valid flags; free count and out_valid clear.
// Depends on cpa_pkg, cpa_ram and cpa_prio.
`timescale 1ns / 1ps

module colored_page_allocator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        action,
	input  logic [cpa_pkg::PAGE_W-1:0]  page_index,
	input  logic [cpa_pkg::MASK_W-1:0]  color_mask,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  status,
	output logic [cpa_pkg::PAGE_W-1:0]  granted_page,
	output logic [cpa_pkg::CNT_W-1:0]   pages_free
);
	import cpa_pkg::*;

	state_t state_q, state_d;

	logic [PAGE_W-1:0]    page_q;
	logic [WORD_W-1:0]    allow_q;
	logic [WORD_AW-1:0]   issue_q;
	logic                 issue_left_q;
	logic                 chk_v_s1;
	logic [WORD_AW-1:0]   chk_word_s1;
	logic                 vbit_s1;
	logic [WORD_AW-1:0]   hit_word_q;
	logic [WORD_W-1:0]    hit_data_q;
	logic [WORD_W-1:0]    hit_cand_q;
	logic [1:0]           res_status_q;
	logic [PAGE_W-1:0]    res_grant_q;
	logic [CNT_W-1:0]     free_total_q;
	logic [NUM_WORDS-1:0] word_vld_q;
	logic                 out_valid_q;
	logic [1:0]           status_q;
	logic [PAGE_W-1:0]    granted_q;
	logic [CNT_W-1:0]     pages_free_q;

	logic                 rd_en, wr_en;
	logic [WORD_AW-1:0]   rd_addr, wr_addr;
	logic [WORD_W-1:0]    wr_data, rd_data;
	logic [WORD_W-1:0]    eff, cand;
	logic                 scan_hit, scan_end;
	logic                 take_in, out_free;
	logic                 free_bad;
	hit_t                 hit;

	cpa_ram #(
		.WIDTH (WORD_W),
		.DEPTH (NUM_WORDS)
	) u_map (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	cpa_prio u_prio (
		.cand (hit_cand_q),
		.hit  (hit)
	);

	// A word never written reads as all used.
	assign eff      = vbit_s1 ? rd_data : '0;
	assign cand     = eff & allow_q;
	assign scan_hit = chk_v_s1 && (|cand);
	assign scan_end = chk_v_s1 && (chk_word_s1 == '0);
	assign take_in  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign free_bad = ({1'b0, page_q} >= PAGES_MAX) || eff[page_q[BIT_W-1:0]];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = action ? S_FRD : S_SCAN;
				end
			end
			S_SCAN: begin
				if (scan_hit) begin
					state_d = S_GRANT;
				end else if (scan_end) begin
					state_d = S_DONE;
				end
			end
			S_GRANT: state_d = S_DONE;
			S_FRD:   state_d = S_FWR;
			S_FWR:   state_d = S_DONE;
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		rd_en    = 1'b0;
		rd_addr  = issue_q;
		wr_en    = 1'b0;
		wr_addr  = hit_word_q;
		wr_data  = hit_data_q & ~(WORD_W'(1) << hit.idx);
		unique case (state_q)
			S_IDLE: in_stall = 1'b0;
			S_SCAN: rd_en = issue_left_q && !scan_hit;
			S_GRANT: wr_en = 1'b1;
			S_FRD: begin
				rd_en   = 1'b1;
				rd_addr = page_q[PAGE_W-1:BIT_W];
			end
			S_FWR: begin
				wr_en   = !free_bad;
				wr_addr = page_q[PAGE_W-1:BIT_W];
				wr_data = eff | (WORD_W'(1) << page_q[BIT_W-1:0]);
			end
			S_DONE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			issue_left_q <= 1'b0;
			chk_v_s1     <= 1'b0;
			free_total_q <= '0;
			word_vld_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			chk_v_s1 <= (state_q == S_SCAN) && rd_en;
			if (take_in && !action) begin
				issue_left_q <= 1'b1;
			end else if ((state_q == S_SCAN) && rd_en) begin
				issue_left_q <= (issue_q != '0);
			end
			if (wr_en) begin
				word_vld_q[wr_addr] <= 1'b1;
			end
			if (state_q == S_GRANT && free_total_q != '0) begin
				free_total_q <= free_total_q - CNT_W'(1);
			end else if (state_q == S_FWR && !free_bad) begin
				free_total_q <= free_total_q + CNT_W'(1);
			end
			// Drop the item once taken, reload when a result is ready.
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		chk_word_s1 <= rd_addr;
		vbit_s1     <= word_vld_q[rd_addr];
		if (take_in) begin
			page_q  <= page_index;
			allow_q <= expand_mask(color_mask);
			issue_q <= WORD_AW'(NUM_WORDS - 1);
		end else if ((state_q == S_SCAN) && rd_en) begin
			issue_q <= issue_q - WORD_AW'(1);
		end
		if (state_q == S_SCAN && scan_hit) begin
			hit_word_q <= chk_word_s1;
			hit_data_q <= eff;
			hit_cand_q <= cand;
		end
		unique case (state_q)
			S_SCAN: begin
				res_status_q <= ST_NONE;
				res_grant_q  <= '0;
			end
			S_GRANT: begin
				res_status_q <= ST_OK;
				res_grant_q  <= {hit_word_q, hit.idx};
			end
			S_FWR: begin
				res_status_q <= free_bad ? ST_IGNORED : ST_OK;
				res_grant_q  <= '0;
			end
			default: ;
		endcase
		if (state_q == S_DONE && out_free) begin
			status_q     <= res_status_q;
			granted_q    <= res_grant_q;
			pages_free_q <= free_total_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign granted_page = granted_q;
	assign pages_free   = pages_free_q;

	a_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ST_OK) |-> (granted_q == '0))
		else $error("granted page not zero on a failed item");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		free_total_q <= PAGES_MAX)
		else $error("free count above page total");

	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == S_GRANT || state_q == S_FWR))
		else $error("map written outside grant or free update");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		take_in |=> (state_q != S_IDLE))
		else $error("accepted item did not start work");

	a_grant_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_GRANT) |-> hit.found)
		else $error("grant without a candidate bit");

endmodule

@@ rtl/cpa_ram.sv @@
// Generic single-port-write, single-port-read synchronous RAM, registered read.
// Standalone; no package needed.
`timescale 1ns / 1ps

module cpa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ rtl/cpa_prio.sv @@
// Highest-set-bit encoder over one free-map word, two levels of groups.
// Depends on cpa_pkg.
`timescale 1ns / 1ps

module cpa_prio (
	input  logic [cpa_pkg::WORD_W-1:0] cand,
	output cpa_pkg::hit_t              hit
);
	import cpa_pkg::*;

	logic [NUM_GRP-1:0] grp_any;
	logic [GRP_IW-1:0]  gsel;
	logic [GRP_W-1:0]   gbits;
	logic [GBIT_W-1:0]  bsel;

	always_comb begin
		for (int g = 0; g < NUM_GRP; g++) begin
			grp_any[g] = |cand[g*GRP_W +: GRP_W];
		end
		gsel = '0;
		for (int g = 0; g < NUM_GRP; g++) begin
			if (grp_any[g]) begin
				gsel = GRP_IW'(g);
			end
		end
		gbits = cand[gsel*GRP_W +: GRP_W];
		bsel  = '0;
		for (int b = 0; b < GRP_W; b++) begin
			if (gbits[b]) begin
				bsel = GBIT_W'(b);
			end
		end
		hit.found = |grp_any;
		hit.idx   = {gsel, bsel};
	end

endmodule

@@ test/cpa_alloc_checker.sv @@
// Action codes for the page allocator bench, plus a checker that mirrors the free map
// and compares every result item against its own prediction. Depends on cpa_pkg.
`timescale 1ns / 1ps

package cpa_tb_pkg;
	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;
endpackage

module cpa_alloc_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic                       action,
	input  logic [cpa_pkg::PAGE_W-1:0] page_index,
	input  logic [cpa_pkg::MASK_W-1:0] color_mask,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic [1:0]                 status,
	input  logic [cpa_pkg::PAGE_W-1:0] granted_page,
	input  logic [cpa_pkg::CNT_W-1:0]  pages_free,
	output int                         fail_count,
	output int                         pending,
	output int                         n_items,
	output int                         n_grants,
	output int                         n_no_match,
	output int                         n_ignored
);
	import cpa_pkg::*;
	import cpa_tb_pkg::*;

	typedef struct packed {
		logic [1:0]        status;
		logic [PAGE_W-1:0] page;
		logic [CNT_W-1:0]  count;
	} alloc_result_t;

	bit                 page_free [NUM_PAGES];
	logic [CNT_W-1:0]   free_count;
	alloc_result_t      results_due [$];

	task automatic report_mismatch(input string what, input int got, input int want_v);
		$display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want_v);
		fail_count++;
	endtask

	// Apply one request to the shadow map and return the result it should produce.
	function automatic alloc_result_t apply_request(input logic act,
			input logic [PAGE_W-1:0] pg, input logic [MASK_W-1:0] mask);
		alloc_result_t r;
		logic          found;
		int            color;
		r.status = ST_OK;
		r.page   = '0;
		found    = 1'b0;
		if (act == ACT_ALLOC) begin
			// Highest-numbered free page with an allowed color wins.
			for (int p = NUM_PAGES - 1; p >= 0; p--) begin
				color = p % NUM_COLORS;
				if (!found && page_free[p] && color < MASK_W && mask[color]) begin
					found  = 1'b1;
					r.page = PAGE_W'(p);
				end
			end
			if (found) begin
				page_free[r.page] = 1'b0;
				if (free_count != '0) free_count = free_count - CNT_W'(1);
			end else begin
				r.status = ST_NONE;
			end
		end else begin
			if (int'(pg) >= NUM_PAGES || page_free[pg]) begin
				r.status = ST_IGNORED;
			end else begin
				page_free[pg] = 1'b1;
				free_count    = free_count + CNT_W'(1);
			end
		end
		r.count = free_count;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		alloc_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_PAGES; i++) page_free[i] = 1'b0;
			free_count = '0;
			results_due.delete();
			pending <= 0;
		end else begin
			// Compare the outgoing item first: it can never belong to an item taken this edge.
			if (out_valid && !out_stall) begin
				if (results_due.size() == 0) begin
					report_mismatch("result with nothing expected, status", int'(status), 0);
				end else begin
					want = results_due.pop_front();
					if (status !== want.status)
						report_mismatch("status", int'(status), int'(want.status));
					if (granted_page !== want.page)
						report_mismatch("granted_page", int'(granted_page), int'(want.page));
					if (pages_free !== want.count)
						report_mismatch("pages_free", int'(pages_free), int'(want.count));
					if (want.status == ST_NONE) n_no_match++;
					if (want.status == ST_IGNORED) n_ignored++;
				end
			end
			if (in_valid && !in_stall) begin
				want = apply_request(action, page_index, color_mask);
				if (action == ACT_ALLOC && want.status == ST_OK) n_grants++;
				results_due.push_back(want);
				n_items++;
			end
			pending <= results_due.size();
		end
	end

endmodule

@@ test/tb_colored_page_allocator.sv @@
// Top of the page allocator bench: clock, reset, item stimulus and output stalls.
// Depends on cpa_pkg, cpa_tb_pkg, the DUT and the checker; only the checker compares.
`timescale 1ns / 1ps

module tb_colored_page_allocator;
	import cpa_pkg::*;
	import cpa_tb_pkg::*;

	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = NUM_WORDS + 40;
	localparam int PHASE_ITEMS  = 406;
	localparam int RUN_LIMIT_NS = 80_000_000;

	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              in_valid   = 1'b0;
	logic              in_stall;
	logic              action     = ACT_ALLOC;
	logic [PAGE_W-1:0] page_index = '0;
	logic [MASK_W-1:0] color_mask = '0;
	logic              out_valid;
	logic              out_stall  = 1'b0;
	logic [1:0]        status;
	logic [PAGE_W-1:0] granted_page;
	logic [CNT_W-1:0]  pages_free;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	logic hold_go      = 1'b0;
	logic hold_started = 1'b0;
	int   hold_left    = 0;

	int fail_count, pending, n_items, n_grants, n_no_match, n_ignored;
	logic [PAGE_W-1:0] freed_recent [$];

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	colored_page_allocator u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.page_index   (page_index),
		.color_mask   (color_mask),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.granted_page (granted_page),
		.pages_free   (pages_free)
	);

	cpa_alloc_checker u_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.page_index   (page_index),
		.color_mask   (color_mask),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.granted_page (granted_page),
		.pages_free   (pages_free),
		.fail_count   (fail_count),
		.pending      (pending),
		.n_items      (n_items),
		.n_grants     (n_grants),
		.n_no_match   (n_no_match),
		.n_ignored    (n_ignored)
	);

	// Receiver: one long hold on request, random stalls otherwise.
	always @(posedge clk) begin
		if (hold_go && !hold_started) begin
			hold_started <= 1'b1;
			hold_left    <= HOLD_CYCLES;
			out_stall    <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	task automatic send_item(input logic act, input logic [PAGE_W-1:0] pg,
			input logic [MASK_W-1:0] mask);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid   <= 1'b1;
		action     <= act;
		page_index <= pg;
		color_mask <= mask;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic random_item();
		logic [PAGE_W-1:0] pg;
		logic [MASK_W-1:0] mask;
		pg = PAGE_W'($urandom_range(NUM_PAGES - 1));
		case ($urandom_range(9))
			0:       mask = '0;
			1:       mask = '1;
			2, 3:    mask = MASK_W'(1) << $urandom_range(MASK_W - 1);
			default: mask = MASK_W'($urandom);
		endcase
		if ($urandom_range(99) < 55) begin
			// Revisit a recent page now and then to get double frees and reuse.
			if (freed_recent.size() > 0 && $urandom_range(99) < 20)
				pg = freed_recent[$urandom_range(freed_recent.size() - 1)];
			freed_recent.push_back(pg);
			if (freed_recent.size() > 32) void'(freed_recent.pop_front());
			send_item(ACT_FREE, pg, mask);
		end else begin
			send_item(ACT_ALLOC, pg, mask);
		end
	endtask

	// Drop valid and hold until every result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty map, edges of the page range, double free, empty and single-color masks.
		send_item(ACT_ALLOC, '0, '1);
		send_item(ACT_FREE, '0, '0);
		send_item(ACT_FREE, '1, '0);
		send_item(ACT_FREE, '1, '1);
		send_item(ACT_ALLOC, '1, '0);
		send_item(ACT_ALLOC, '0, 16'h8000);
		send_item(ACT_ALLOC, '0, 16'h8000);
		send_item(ACT_ALLOC, '0, 16'h0001);
		send_item(ACT_ALLOC, '0, '1);
		send_item(ACT_FREE, 12'd17, '0);
		send_item(ACT_FREE, 12'd4094, '0);
		send_item(ACT_FREE, 12'h800, '0);
		send_item(ACT_FREE, 12'h800, '1);
		send_item(ACT_ALLOC, '0, '1);
		send_item(ACT_ALLOC, '0, 16'h0002);
		send_item(ACT_ALLOC, '0, 16'h0001);
		send_item(ACT_FREE, 12'hAAA, '0);
		send_item(ACT_FREE, 12'h555, '0);
		send_item(ACT_ALLOC, 12'h555, 16'h0400);
		send_item(ACT_ALLOC, 12'hAAA, 16'hAAAA);
		send_item(ACT_ALLOC, '0, 16'h5555);
		send_item(ACT_ALLOC, '0, '1);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0:       begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
				1:       begin send_idle_pct = 77; recv_stall_pct <= 0;  end
				2:       begin send_idle_pct = 0;  recv_stall_pct <= 77; end
				default: begin send_idle_pct = 25; recv_stall_pct <= 25; end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Hold the output long enough that the block backs up onto its input.
				if (ph == 0 && n == 100) hold_go <= 1'b1;
				random_item();
			end
			drain();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d items: %0d grants, %0d with no allowed page, %0d ignored frees,",
			n_items, n_grants, n_no_match, n_ignored);
		$display("over four pacing mixes and one long output hold.");
		if (fail_count == 0 && pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("Timeout with %0d results still outstanding", pending);
		$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/cpa_pkg.sv
rtl/cpa_ram.sv
rtl/cpa_prio.sv
rtl/colored_page_allocator.sv
test/cpa_alloc_checker.sv
test/tb_colored_page_allocator.sv
